FILE: hw/rtl/ptsch_pkg.sv
// Shared types and constants for the periodic timer scheduler.
package ptsch_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int MAX_RESULTS   = 16;
    localparam int FIRE_CNT_W    = 4;
    localparam int TIME_W        = 32;
    localparam int TICKS_W       = 20;
    localparam int TASK_W        = 8;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_SCHED = 1'b1;

    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_FIRED    = 2'd1;
    localparam logic [1:0] EV_ACCEPTED = 2'd2;
    localparam logic [1:0] EV_REJECTED = 2'd3;

    typedef struct packed {
        logic               opcode;
        logic [TASK_W-1:0]  task_id;
        logic [TICKS_W-1:0] delay_ticks;
        logic               repeating;
        logic [TICKS_W-1:0] interval_ticks;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        event_kind;
        logic [TASK_W-1:0] fired_task_id;
        logic [TIME_W-1:0] fire_time;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic [TIME_W-1:0]  deadline;
        logic [TICKS_W-1:0] interval;
        logic               rep_en;
        logic [TASK_W-1:0]  task_id;
    } slot_entry_t;

    localparam int SLOT_ENTRY_W = $bits(slot_entry_t);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

endpackage

FILE: hw/rtl/ptsch_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ptsch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/periodic_timer_scheduler.sv
// Timer queue top level: slot table in RAM, scan engine and result register.
//
//  Channel   Signals                      Direction  Content
//  in        in_valid, in_ready, in_data  to block   tick or schedule request
//  out       out_valid, out_ready, out_data from block one result per transfer
//  cfg       cfg_wr_en, cfg_wr_data       to block   timer_enable register
//
// A schedule request gives one result.
// A tick makes one pass over the slot RAM for each task it fires, at least one pass
// when enabled with any slot in use; a pass reads the slots in turn through the single
// RAM read port. A disabled tick, or a tick with no slot in use, goes straight to emit.
// Reset clears time, the enable register and all slot valid bits; no clearing pass.
// A stalled output holds the block in its emit state until the result is taken.
module periodic_timer_scheduler #(
    parameter int SLOTS = ptsch_pkg::SLOTS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ptsch_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ptsch_pkg::out_item_t out_data,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam logic [ptsch_pkg::FIRE_CNT_W-1:0] LAST_FIRE =
        ptsch_pkg::FIRE_CNT_W'(ptsch_pkg::MAX_RESULTS - 1);

    ptsch_pkg::state_t state_reg, state_next;
    logic                         out_valid_reg, out_valid_next;
    ptsch_pkg::out_item_t         out_data_reg, out_data_next;
    logic [SLOTS-1:0]             slot_valid_reg, slot_valid_next;
    logic [ptsch_pkg::TIME_W-1:0] time_now_reg, time_now_next;
    logic                         timer_enable_reg;
    logic                         iss_reg, iss_next;
    logic                         cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]             idx_reg, idx_next;
    logic [IDX_W-1:0]             cmp_idx_reg, cmp_idx_next;
    logic                         best_found_reg, best_found_next;
    logic                         more_reg, more_next;
    logic [ptsch_pkg::TIME_W-1:0] best_age_reg, best_age_next;
    logic [IDX_W-1:0]             best_idx_reg, best_idx_next;
    ptsch_pkg::slot_entry_t       best_entry_reg, best_entry_next;
    logic [ptsch_pkg::FIRE_CNT_W-1:0] fire_cnt_reg, fire_cnt_next;

    logic                              ram_wr_en;
    logic [IDX_W-1:0]                  ram_wr_addr;
    ptsch_pkg::slot_entry_t            ram_wr_entry;
    logic                              ram_rd_en;
    logic [ptsch_pkg::SLOT_ENTRY_W-1:0] ram_rd_data;

    logic                         free_found;
    logic [IDX_W-1:0]             free_idx;
    ptsch_pkg::slot_entry_t       cmp_entry;
    logic [ptsch_pkg::TIME_W-1:0] cmp_age;
    logic                         cmp_due;
    logic                         cmp_better;
    logic                         can_emit;
    logic                         fire_last;
    logic [ptsch_pkg::TICKS_W-1:0] rearm_ivl;

    ptsch_ram #(
        .WIDTH (ptsch_pkg::SLOT_ENTRY_W),
        .DEPTH (SLOTS),
        .ADDR_W(IDX_W)
    ) u_slot_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_entry),
        .rd_en  (ram_rd_en),
        .rd_addr(idx_reg),
        .rd_data(ram_rd_data)
    );

    // The lowest free slot takes a new task.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!slot_valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // A slot is due when the wrapped age is below half the time range.
    assign cmp_entry  = ptsch_pkg::slot_entry_t'(ram_rd_data);
    assign cmp_age    = time_now_reg - cmp_entry.deadline;
    assign cmp_due    = cmp_vld_reg && slot_valid_reg[cmp_idx_reg] && !cmp_age[31];
    assign cmp_better = cmp_due && (!best_found_reg || (cmp_age > best_age_reg));

    assign can_emit  = !out_valid_reg || out_ready;
    assign fire_last = !more_reg || (fire_cnt_reg == LAST_FIRE);
    assign rearm_ivl = (best_entry_reg.interval == '0) ? ptsch_pkg::TICKS_W'(1)
                                                       : best_entry_reg.interval;

    assign in_ready  = (state_reg == ptsch_pkg::ST_IDLE) && can_emit;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        slot_valid_next = slot_valid_reg;
        time_now_next   = time_now_reg;
        iss_next        = iss_reg;
        cmp_vld_next    = 1'b0;
        idx_next        = idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        best_found_next = best_found_reg;
        more_next       = more_reg;
        best_age_next   = best_age_reg;
        best_idx_next   = best_idx_reg;
        best_entry_next = best_entry_reg;
        fire_cnt_next   = fire_cnt_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = best_idx_reg;
        ram_wr_entry    = best_entry_reg;
        ram_rd_en       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ptsch_pkg::ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (in_data.opcode == ptsch_pkg::OP_SCHED)
                    begin
                        out_valid_next               = 1'b1;
                        out_data_next.event_kind     = free_found ? ptsch_pkg::EV_ACCEPTED
                                                                  : ptsch_pkg::EV_REJECTED;
                        out_data_next.fired_task_id  = in_data.task_id;
                        out_data_next.fire_time      = time_now_reg;
                        out_data_next.last           = 1'b1;
                        if (free_found)
                        begin
                            ram_wr_en             = 1'b1;
                            ram_wr_addr           = free_idx;
                            ram_wr_entry.deadline = time_now_reg
                                + ptsch_pkg::TIME_W'(in_data.delay_ticks);
                            ram_wr_entry.interval = in_data.interval_ticks;
                            ram_wr_entry.rep_en   = in_data.repeating;
                            ram_wr_entry.task_id  = in_data.task_id;
                            slot_valid_next[free_idx] = 1'b1;
                        end
                    end
                    else
                    begin
                        time_now_next   = time_now_reg + 1'b1;
                        fire_cnt_next   = '0;
                        best_found_next = 1'b0;
                        more_next       = 1'b0;
                        if (timer_enable_reg && (|slot_valid_reg))
                        begin
                            state_next = ptsch_pkg::ST_SCAN;
                            idx_next   = '0;
                            iss_next   = 1'b1;
                        end
                        else
                        begin
                            state_next = ptsch_pkg::ST_EMIT;
                        end
                    end
                end
            end

            ptsch_pkg::ST_SCAN:
            begin
                ram_rd_en    = iss_reg;
                cmp_vld_next = iss_reg;
                cmp_idx_next = idx_reg;
                if (iss_reg)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        iss_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                if (cmp_due && best_found_reg)
                begin
                    more_next = 1'b1;
                end
                if (cmp_better)
                begin
                    best_found_next = 1'b1;
                    best_age_next   = cmp_age;
                    best_idx_next   = cmp_idx_reg;
                    best_entry_next = cmp_entry;
                end
                if (cmp_vld_reg && (cmp_idx_reg == LAST_IDX))
                begin
                    state_next = ptsch_pkg::ST_EMIT;
                end
            end

            ptsch_pkg::ST_EMIT:
            begin
                if (can_emit)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.fire_time = time_now_reg;
                    if (best_found_reg)
                    begin
                        out_data_next.event_kind    = ptsch_pkg::EV_FIRED;
                        out_data_next.fired_task_id = best_entry_reg.task_id;
                        out_data_next.last          = fire_last;
                        if (best_entry_reg.rep_en)
                        begin
                            ram_wr_en             = 1'b1;
                            ram_wr_entry.deadline = time_now_reg
                                + ptsch_pkg::TIME_W'(rearm_ivl);
                        end
                        else
                        begin
                            slot_valid_next[best_idx_reg] = 1'b0;
                        end
                        if (fire_last)
                        begin
                            state_next = ptsch_pkg::ST_IDLE;
                        end
                        else
                        begin
                            state_next      = ptsch_pkg::ST_SCAN;
                            fire_cnt_next   = fire_cnt_reg + 1'b1;
                            best_found_next = 1'b0;
                            more_next       = 1'b0;
                            idx_next        = '0;
                            iss_next        = 1'b1;
                        end
                    end
                    else
                    begin
                        out_data_next.event_kind    = ptsch_pkg::EV_NONE;
                        out_data_next.fired_task_id = '0;
                        out_data_next.last          = 1'b1;
                        state_next                  = ptsch_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ptsch_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ptsch_pkg::ST_IDLE;
            out_valid_reg    <= 1'b0;
            slot_valid_reg   <= '0;
            time_now_reg     <= '0;
            timer_enable_reg <= 1'b0;
            iss_reg          <= 1'b0;
            cmp_vld_reg      <= 1'b0;
            best_found_reg   <= 1'b0;
            more_reg         <= 1'b0;
            fire_cnt_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            slot_valid_reg <= slot_valid_next;
            time_now_reg   <= time_now_next;
            iss_reg        <= iss_next;
            cmp_vld_reg    <= cmp_vld_next;
            best_found_reg <= best_found_next;
            more_reg       <= more_next;
            fire_cnt_reg   <= fire_cnt_next;
            if (cfg_wr_en)
            begin
                timer_enable_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        idx_reg        <= idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        best_age_reg   <= best_age_next;
        best_idx_reg   <= best_idx_next;
        best_entry_reg <= best_entry_next;
    end

`ifndef SYNTH
    // The slot picked for firing must still hold a live task.
    a_fire_slot_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ptsch_pkg::ST_EMIT && best_found_reg) |-> slot_valid_reg[best_idx_reg])
        else $error("fired slot is not valid");

    // An accepted schedule request must claim a previously free slot.
    a_sched_claims_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.opcode == ptsch_pkg::OP_SCHED && free_found)
        |=> ($countones(slot_valid_reg) == $countones($past(slot_valid_reg)) + 1))
        else $error("schedule did not claim a slot");

    // The slot RAM is never written while a scan pass reads it.
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ptsch_pkg::ST_SCAN) |-> !ram_wr_en)
        else $error("slot RAM written during scan");

    // A fired result ends the tick once the per-tick limit is reached.
    a_fire_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ptsch_pkg::ST_EMIT && can_emit && best_found_reg
            && fire_cnt_reg == LAST_FIRE) |=> out_data_reg.last)
        else $error("fire limit exceeded without last");
`endif

endmodule

FILE: test/tb.sv
// Self-checking testbench for the periodic timer scheduler.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS          = ptsch_pkg::SLOTS_DEFAULT;
    localparam int SETTLE_CYCLES  = 2 * (SLOTS + 2) + 8;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int LIMIT_CYCLES   = 2000000;
    localparam logic [ptsch_pkg::TICKS_W-1:0] TICKS_MAX = '1;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    ptsch_pkg::in_item_t  in_data     = '0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    ptsch_pkg::out_item_t out_data;
    logic                 cfg_wr_en   = 1'b0;
    logic                 cfg_wr_data = 1'b0;

    logic [ptsch_pkg::TIME_W-1:0]  now_ticks;
    logic                          enable_model;
    logic                          slot_used   [SLOTS];
    logic [ptsch_pkg::TIME_W-1:0]  slot_due_at [SLOTS];
    logic [ptsch_pkg::TICKS_W-1:0] slot_period [SLOTS];
    logic                          slot_rearm  [SLOTS];
    logic [ptsch_pkg::TASK_W-1:0]  slot_tag    [SLOTS];

    ptsch_pkg::out_item_t expected_events[$];
    int        fail_count     = 0;
    int        cycle_count    = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    logic      holdoff_req    = 1'b0;
    int        holdoff_left   = HOLDOFF_CYCLES;
    int        repeat_budget  = 4;

    periodic_timer_scheduler #(
        .SLOTS(SLOTS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (holdoff_req && holdoff_left > 0)
        begin
            out_ready <= 1'b0;
            holdoff_left = holdoff_left - 1;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        ptsch_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_events.size() == 0)
            begin
                fail_count = fail_count + 1;
                $display("%0t: unexpected transfer: kind %0d id %0h time %0d last %0b",
                         $time, out_data.event_kind, out_data.fired_task_id,
                         out_data.fire_time, out_data.last);
            end
            else
            begin
                want = expected_events.pop_front();
                if (out_data.event_kind !== want.event_kind)
                begin
                    fail_count = fail_count + 1;
                    $display("%0t: event_kind expected %0d, got %0d",
                             $time, want.event_kind, out_data.event_kind);
                end
                if (out_data.fired_task_id !== want.fired_task_id)
                begin
                    fail_count = fail_count + 1;
                    $display("%0t: fired_task_id expected %0h, got %0h",
                             $time, want.fired_task_id, out_data.fired_task_id);
                end
                if (out_data.fire_time !== want.fire_time)
                begin
                    fail_count = fail_count + 1;
                    $display("%0t: fire_time expected %0d, got %0d",
                             $time, want.fire_time, out_data.fire_time);
                end
                if (out_data.last !== want.last)
                begin
                    fail_count = fail_count + 1;
                    $display("%0t: last expected %0b, got %0b",
                             $time, want.last, out_data.last);
                end
            end
        end
    end

    function automatic int free_slots();
        int count;
        count = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!slot_used[i])
                count++;
        end
        return count;
    endfunction

    task automatic predict_events(input ptsch_pkg::in_item_t item);
        ptsch_pkg::out_item_t          ev;
        ptsch_pkg::out_item_t          held;
        logic                          have_held;
        int                            slot;
        int                            best;
        int                            fired;
        logic [ptsch_pkg::TIME_W-1:0]  age;
        logic [ptsch_pkg::TIME_W-1:0]  best_age;
        logic [ptsch_pkg::TICKS_W-1:0] period;
        logic                          searching;
        if (item.opcode == ptsch_pkg::OP_SCHED)
        begin
            slot = -1;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!slot_used[i] && slot < 0)
                    slot = i;
            end
            ev.fired_task_id = item.task_id;
            ev.fire_time     = now_ticks;
            ev.last          = 1'b1;
            if (slot < 0)
            begin
                ev.event_kind = ptsch_pkg::EV_REJECTED;
            end
            else
            begin
                ev.event_kind     = ptsch_pkg::EV_ACCEPTED;
                slot_used[slot]   = 1'b1;
                slot_due_at[slot] = now_ticks + ptsch_pkg::TIME_W'(item.delay_ticks);
                slot_period[slot] = item.interval_ticks;
                slot_rearm[slot]  = item.repeating;
                slot_tag[slot]    = item.task_id;
            end
            expected_events.push_back(ev);
        end
        else
        begin
            now_ticks = now_ticks + 1;
            fired     = 0;
            have_held = 1'b0;
            searching = enable_model;
            while (searching && fired < ptsch_pkg::MAX_RESULTS)
            begin
                best     = -1;
                best_age = '0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    age = now_ticks - slot_due_at[i];
                    if (slot_used[i] && !age[ptsch_pkg::TIME_W-1]
                        && (best < 0 || age > best_age))
                    begin
                        best     = i;
                        best_age = age;
                    end
                end
                if (best < 0)
                begin
                    searching = 1'b0;
                end
                else
                begin
                    if (have_held)
                        expected_events.push_back(held);
                    held.event_kind    = ptsch_pkg::EV_FIRED;
                    held.fired_task_id = slot_tag[best];
                    held.fire_time     = now_ticks;
                    held.last          = 1'b0;
                    have_held          = 1'b1;
                    fired++;
                    if (slot_rearm[best])
                    begin
                        period = (slot_period[best] == '0) ? ptsch_pkg::TICKS_W'(1)
                                                           : slot_period[best];
                        slot_due_at[best] = now_ticks + ptsch_pkg::TIME_W'(period);
                    end
                    else
                    begin
                        slot_used[best] = 1'b0;
                    end
                end
            end
            if (!have_held)
            begin
                held.event_kind    = ptsch_pkg::EV_NONE;
                held.fired_task_id = '0;
                held.fire_time     = now_ticks;
            end
            held.last = 1'b1;
            expected_events.push_back(held);
        end
    endtask

    function automatic ptsch_pkg::in_item_t tick_item();
        ptsch_pkg::in_item_t item;
        item.opcode         = ptsch_pkg::OP_TICK;
        item.task_id        = ptsch_pkg::TASK_W'($urandom_range(0, 255));
        item.delay_ticks    = ptsch_pkg::TICKS_W'($urandom_range(0, TICKS_MAX));
        item.repeating      = 1'($urandom_range(0, 1));
        item.interval_ticks = ptsch_pkg::TICKS_W'($urandom_range(0, TICKS_MAX));
        return item;
    endfunction

    function automatic ptsch_pkg::in_item_t sched_item(input int id, input int delay,
                                                       input logic rep, input int period);
        ptsch_pkg::in_item_t item;
        item.opcode         = ptsch_pkg::OP_SCHED;
        item.task_id        = ptsch_pkg::TASK_W'(id);
        item.delay_ticks    = ptsch_pkg::TICKS_W'(delay);
        item.repeating      = rep;
        item.interval_ticks = ptsch_pkg::TICKS_W'(period);
        return item;
    endfunction

    function automatic ptsch_pkg::in_item_t random_item(input int tick_pct);
        ptsch_pkg::in_item_t item;
        logic                rep;
        if ($urandom_range(0, 99) < tick_pct)
            return tick_item();
        if (free_slots() == 0)
        begin
            item        = tick_item();
            item.opcode = ptsch_pkg::OP_SCHED;
            return item;
        end
        rep = (repeat_budget > 0 && $urandom_range(0, 15) == 0);
        if (rep)
            repeat_budget--;
        return sched_item($urandom_range(0, 255), $urandom_range(0, 15), rep,
                          rep ? $urandom_range(0, 7) : $urandom_range(0, TICKS_MAX));
    endfunction

    task automatic send_item(input ptsch_pkg::in_item_t item);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_events(item);
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_enable(input logic value);
        wait_quiet();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        enable_model = value;
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // While disabled, time advances but a due task must wait for the enable.
    task automatic test_disabled_tick();
        send_item(tick_item());
        send_item(sched_item('h5A, 0, 1'b0, 0));
        send_item(tick_item());
        write_enable(1'b1);
        send_item(tick_item());
    endtask

    task automatic test_fire_basics();
        send_item(tick_item());
        send_item(sched_item('h00, 0, 1'b0, 0));
        send_item(tick_item());
        send_item(sched_item('hFF, int'(TICKS_MAX), 1'b1, int'(TICKS_MAX)));
        send_item(sched_item('hC3, 1, 1'b1, 0));
        send_item(tick_item());
        send_item(tick_item());
    endtask

    task automatic test_ordering();
        send_item(sched_item('h11, 2, 1'b0, 0));
        send_item(sched_item('h22, 2, 1'b0, 0));
        send_item(sched_item('h11, 2, 1'b0, 0));
        send_item(sched_item('h33, 1, 1'b0, 0));
        send_item(tick_item());
        send_item(tick_item());
    endtask

    // Fill every slot, offer schedules that must be refused, then drain by ticking.
    task automatic test_full_queue();
        ptsch_pkg::in_item_t item;
        while (free_slots() > 0)
            send_item(sched_item($urandom_range(0, 255), $urandom_range(3, 20), 1'b0,
                                 $urandom_range(0, TICKS_MAX)));
        repeat (4)
        begin
            item        = tick_item();
            item.opcode = ptsch_pkg::OP_SCHED;
            send_item(item);
        end
        repeat (24) send_item(tick_item());
    endtask

    // The receiver holds off while the sender keeps offering, so the input backs up.
    task automatic test_holdoff();
        holdoff_req <= 1'b1;
        repeat (30) send_item(random_item(40));
        wait_quiet();
    endtask

    task automatic test_random_phase(input int count, input int tick_pct);
        for (int n = 0; n < count; n++)
        begin
            send_item(random_item(tick_pct));
            if (n % 25 == 24)
                wait_quiet();
        end
    endtask

    initial
    begin
        now_ticks    = '0;
        enable_model = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_used[i]   = 1'b0;
            slot_due_at[i] = '0;
            slot_period[i] = '0;
            slot_rearm[i]  = 1'b0;
            slot_tag[i]    = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(0, 0);
        test_disabled_tick();
        test_fire_basics();
        test_ordering();

        set_idling(24, 24);
        test_full_queue();

        set_idling(0, 0);
        test_holdoff();

        test_random_phase(70, 55);
        set_idling(48, 0);
        write_enable(1'b0);
        test_random_phase(70, 45);
        set_idling(0, 48);
        write_enable(1'b1);
        test_random_phase(70, 55);
        set_idling(24, 24);
        test_random_phase(70, 55);

        wait_quiet();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
